[sv/job_slot_tracker_defines.svh]
// Assertion macros used by the checker file.
`ifndef JOB_SLOT_TRACKER_DEFINES_SVH
`define JOB_SLOT_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JST_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/jst_pkg.sv]
`timescale 1ns / 1ps

package jst_pkg;

  // Parameter defaults
  localparam int unsigned SLOTS_DEF     = 8;
  localparam int unsigned MAX_BYTES_DEF = 256;
  localparam int unsigned ID_BITS_DEF   = 32;

  // Fixed port widths
  localparam int unsigned IO_ID_W    = 32;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned SIZE_CMP_W = 17;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  // Request queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register index as seen on paddr[2]
  localparam logic REG_IDX_ENABLE = 1'b0;

  typedef enum logic [2:0] {
    REQ_SUBMIT,
    REQ_STATUS,
    REQ_RETRY,
    REQ_RELEASE,
    REQ_SIZE_CHECK,
    REQ_CAPACITY,
    REQ_DISPATCH,
    REQ_COMPLETE
  } req_e;

  typedef enum logic [1:0] {
    ST_FREE,
    ST_PEND,
    ST_DONE,
    ST_FAIL
  } slot_st_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } bk_state_e;

  // Classified request as it travels from front to back
  typedef struct packed {
    req_e              req;
    logic [IO_ID_W-1:0] job_id;
    logic [SIZE_W-1:0] job_size;
    logic              success;
    logic              size_ok;
  } item_t;

endpackage

[sv/job_slot_tracker.sv]
// Job slot tracker: a table of SLOTS job slots (id, size, status).
// Request channel: in_valid_i/in_ready_o carry req_type_i, job_id_i,
// job_size_i and success_i; every request gives exactly one result on
// out_valid_o/out_ready_i as ok_o, out_id_o and job_status_o, in order.
// Configuration: APB-style port, register enable at byte address 0,
// written in the access phase, pready always high, readable.
// An accepted request passes the queue and the back end's pick-up,
// scan and write-back steps before its result is registered.
// The back end takes a new request only when done with the last one;
// its scan reads the id/size memory one slot per cycle, followed by
// a write-back step and a pick-up step.
// A two-entry queue after the front end takes up to two further
// requests while the back end works or a result waits.
// Receiver stall: the result register holds its item; the back end waits
// in its write-back step and the queue fills, then in_ready_o drops.
// Reset: all slots free, next id one, no job running, enable off;
// id and size entries are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module job_slot_tracker import jst_pkg::*; #(
  parameter int unsigned SLOTS     = SLOTS_DEF,
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF,
  parameter int unsigned ID_BITS   = ID_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic [IO_ID_W-1:0] job_id_i,
  input  logic [SIZE_W-1:0]  job_size_i,
  input  logic               success_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic [IO_ID_W-1:0] out_id_o,
  output logic [1:0]         job_status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic  enable_q;
  logic  cfg_wr;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // Register write in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_ENABLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_wr) begin
      enable_q <= pwdata[0];
    end
  end

  // Read back
  assign prdata = (paddr[2] == REG_IDX_ENABLE) ? PDATA_W'(enable_q) : '0;

  jst_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .job_id_i     (job_id_i),
    .job_size_i   (job_size_i),
    .success_i    (success_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  jst_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  jst_back #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .enable_i     (enable_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_item_i   (pop_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .out_id_o     (out_id_o),
    .job_status_o (job_status_o)
  );

endmodule

[sv/jst_front.sv]
`timescale 1ns / 1ps

module jst_front import jst_pkg::*; #(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic [IO_ID_W-1:0] job_id_i,
  input  logic [SIZE_W-1:0]  job_size_i,
  input  logic               success_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output item_t              push_item_o
);

  logic [SIZE_CMP_W-1:0] size_ext;

  // Check the submit size range up front
  assign size_ext = SIZE_CMP_W'(job_size_i);

  always_comb begin
    push_item_o.req      = req_e'(req_type_i);
    push_item_o.job_id   = job_id_i;
    push_item_o.job_size = job_size_i;
    push_item_o.success  = success_i;
    push_item_o.size_ok  = (job_size_i != '0) && (size_ext <= SIZE_CMP_W'(MAX_BYTES));
  end

  // Accept whenever the queue has room
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

[sv/jst_queue.sv]
`timescale 1ns / 1ps

module jst_queue import jst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(QUEUE_DEPTH + 1);

  item_t            q_mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != CNTW'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = q_mem[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[sv/jst_back.sv]
`timescale 1ns / 1ps

module jst_back import jst_pkg::*; #(
  parameter int unsigned SLOTS   = SLOTS_DEF,
  parameter int unsigned ID_BITS = ID_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               enable_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  item_t              pop_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic [IO_ID_W-1:0] out_id_o,
  output logic [1:0]         job_status_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned XW = (ID_BITS > IO_ID_W) ? ID_BITS : IO_ID_W;
  localparam int unsigned EW = ID_BITS + SIZE_W;

  bk_state_e state_q, state_d;

  // Current request
  item_t cur_q;

  // Slot table: id and size in memory, status in flops
  logic [EW-1:0] tbl_mem [SLOTS];
  logic [EW-1:0] tbl_rd_q;
  slot_st_e      slot_st_q [SLOTS];
  slot_st_e      st_rd_q;

  logic [CW-1:0] scan_q;
  logic [IW-1:0] scan_idx;
  logic          ev_vld_q;
  logic [IW-1:0] ev_idx_q;

  // Scan findings
  logic               free_fnd_q;
  logic [IW-1:0]      free_idx_q;
  logic               hit_fnd_q;
  logic [IW-1:0]      hit_idx_q;
  slot_st_e           hit_st_q;
  logic [SIZE_W-1:0]  hit_size_q;
  logic               cand_fnd_q;
  logic [IW-1:0]      cand_idx_q;
  logic [ID_BITS-1:0] cand_id_q;
  logic               cand_pend_q;
  logic [ID_BITS-1:0] bsy_id_q;

  logic [ID_BITS-1:0] next_id_q;
  logic               busy_q;
  logic [IW-1:0]      busy_slot_q;

  // Result register
  logic               out_vld_q;
  logic               res_ok_q;
  logic [IO_ID_W-1:0] res_id_q;
  slot_st_e           res_st_q;

  logic               start;
  logic               rd_issue;
  logic               scan_done;
  logic               res_free;
  logic               commit;

  logic [XW-1:0]      key_ext;
  logic [ID_BITS-1:0] key;
  logic [ID_BITS-1:0] ev_id;
  logic [SIZE_W-1:0]  ev_size;
  logic               ev_free;
  logic               ev_hit;
  logic               ev_run;

  logic               res_ok;
  logic [ID_BITS-1:0] res_oid;
  slot_st_e           res_st;
  logic [XW-1:0]      oid_ext;
  logic               wr_tbl;
  logic               st_wr;
  logic [IW-1:0]      st_wr_idx;
  slot_st_e           st_wr_val;
  logic               id_adv;
  logic               set_busy;
  logic               clr_busy;

  assign key_ext  = XW'(cur_q.job_id);
  assign key      = key_ext[ID_BITS-1:0];
  assign scan_idx = scan_q[IW-1:0];
  assign res_free = !out_vld_q || out_ready_i;
  assign scan_done = (scan_q == CW'(SLOTS)) && ev_vld_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (pop_valid_i) state_d = BK_SCAN;
      BK_SCAN:   if (scan_done) state_d = BK_FINISH;
      BK_FINISH: if (res_free) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_ready_o = 1'b0;
    rd_issue    = 1'b0;
    commit      = 1'b0;
    unique case (state_q)
      BK_IDLE:   pop_ready_o = 1'b1;
      BK_SCAN:   rd_issue    = (scan_q != CW'(SLOTS));
      BK_FINISH: commit      = res_free;
      default:   pop_ready_o = 1'b0;
    endcase
  end

  assign start = pop_valid_i && pop_ready_o;

  // Classify the entry read in the previous cycle
  assign ev_id   = tbl_rd_q[EW-1:SIZE_W];
  assign ev_size = tbl_rd_q[SIZE_W-1:0];
  assign ev_free = (st_rd_q == ST_FREE);
  assign ev_hit  = !ev_free && (ev_id == key);
  assign ev_run  = (st_rd_q == ST_PEND) || (st_rd_q == ST_FAIL);

  // Carry out the request from the scan findings
  always_comb begin
    res_ok    = 1'b0;
    res_oid   = '0;
    res_st    = ST_FREE;
    wr_tbl    = 1'b0;
    st_wr     = 1'b0;
    st_wr_idx = hit_idx_q;
    st_wr_val = ST_FREE;
    id_adv    = 1'b0;
    set_busy  = 1'b0;
    clr_busy  = 1'b0;
    unique case (cur_q.req)
      REQ_SUBMIT: begin
        if (cur_q.size_ok && enable_i && (next_id_q != '0) && free_fnd_q) begin
          wr_tbl    = 1'b1;
          st_wr     = 1'b1;
          st_wr_idx = free_idx_q;
          st_wr_val = ST_PEND;
          id_adv    = 1'b1;
          res_ok    = 1'b1;
          res_oid   = next_id_q;
          res_st    = ST_PEND;
        end
      end
      REQ_STATUS: begin
        if (hit_fnd_q) begin
          res_ok = 1'b1;
          res_st = hit_st_q;
        end
      end
      REQ_RETRY: begin
        if (hit_fnd_q) begin
          res_st = hit_st_q;
          if (hit_st_q == ST_FAIL) begin
            st_wr     = 1'b1;
            st_wr_val = ST_PEND;
            res_ok    = 1'b1;
            res_st    = ST_PEND;
          end
        end
      end
      REQ_RELEASE: begin
        if (hit_fnd_q) begin
          res_st = hit_st_q;
          if (hit_st_q == ST_DONE) begin
            st_wr     = 1'b1;
            st_wr_val = ST_FREE;
            res_ok    = 1'b1;
            res_st    = ST_FREE;
          end
        end
      end
      REQ_SIZE_CHECK: begin
        if (hit_fnd_q) begin
          res_st = hit_st_q;
          res_ok = (hit_st_q == ST_DONE) && (hit_size_q == cur_q.job_size);
        end
      end
      REQ_CAPACITY: begin
        res_ok = enable_i && free_fnd_q;
      end
      REQ_DISPATCH: begin
        // a failed job with the lowest id holds back all later ones
        if (!busy_q && cand_fnd_q && cand_pend_q) begin
          set_busy = 1'b1;
          res_ok   = 1'b1;
          res_oid  = cand_id_q;
          res_st   = ST_PEND;
        end
      end
      REQ_COMPLETE: begin
        if (busy_q) begin
          st_wr     = 1'b1;
          st_wr_idx = busy_slot_q;
          st_wr_val = cur_q.success ? ST_DONE : ST_FAIL;
          clr_busy  = 1'b1;
          res_ok    = 1'b1;
          res_oid   = bsy_id_q;
          res_st    = st_wr_val;
        end
      end
      default: res_ok = 1'b0;
    endcase
  end

  assign oid_ext = XW'(res_oid);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      scan_q      <= '0;
      ev_vld_q    <= 1'b0;
      free_fnd_q  <= 1'b0;
      hit_fnd_q   <= 1'b0;
      cand_fnd_q  <= 1'b0;
      next_id_q   <= ID_BITS'(1);
      busy_q      <= 1'b0;
      busy_slot_q <= '0;
      out_vld_q   <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_st_q[i] <= ST_FREE;
      end
    end else begin
      state_q  <= state_d;
      ev_vld_q <= rd_issue;
      if (start) begin
        scan_q     <= '0;
        free_fnd_q <= 1'b0;
        hit_fnd_q  <= 1'b0;
        cand_fnd_q <= 1'b0;
      end else begin
        if (rd_issue) begin
          scan_q <= scan_q + 1'b1;
        end
        if (ev_vld_q && ev_free) begin
          free_fnd_q <= 1'b1;
        end
        if (ev_vld_q && ev_hit) begin
          hit_fnd_q <= 1'b1;
        end
        if (ev_vld_q && ev_run) begin
          cand_fnd_q <= 1'b1;
        end
      end
      if (commit) begin
        if (st_wr) begin
          slot_st_q[st_wr_idx] <= st_wr_val;
        end
        if (id_adv) begin
          next_id_q <= next_id_q + 1'b1;
        end
        if (set_busy) begin
          busy_q      <= 1'b1;
          busy_slot_q <= cand_idx_q;
        end else if (clr_busy) begin
          busy_q <= 1'b0;
        end
      end
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload: table, reads, findings, result
  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q <= pop_item_i;
    end
    if (rd_issue) begin
      tbl_rd_q <= tbl_mem[scan_idx];
      st_rd_q  <= slot_st_q[scan_idx];
      ev_idx_q <= scan_idx;
    end
    if (ev_vld_q && ev_free && !free_fnd_q) begin
      free_idx_q <= ev_idx_q;
    end
    if (ev_vld_q && ev_hit && !hit_fnd_q) begin
      hit_idx_q  <= ev_idx_q;
      hit_st_q   <= st_rd_q;
      hit_size_q <= ev_size;
    end
    if (ev_vld_q && ev_run && (!cand_fnd_q || (ev_id < cand_id_q))) begin
      cand_idx_q  <= ev_idx_q;
      cand_id_q   <= ev_id;
      cand_pend_q <= (st_rd_q == ST_PEND);
    end
    if (ev_vld_q && (ev_idx_q == busy_slot_q)) begin
      bsy_id_q <= ev_id;
    end
    if (commit && wr_tbl) begin
      tbl_mem[free_idx_q] <= {next_id_q, cur_q.job_size};
    end
    if (commit) begin
      res_ok_q <= res_ok;
      res_id_q <= oid_ext[IO_ID_W-1:0];
      res_st_q <= res_st;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign ok_o         = res_ok_q;
  assign out_id_o     = res_id_q;
  assign job_status_o = res_st_q;

endmodule

[sv/jst_checker.sv]
`timescale 1ns / 1ps
`include "job_slot_tracker_defines.svh"

module jst_checker import jst_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [2:0]         req_type_i,
  input logic [IO_ID_W-1:0] job_id_i,
  input logic [SIZE_W-1:0]  job_size_i,
  input logic               success_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               ok_o,
  input logic [IO_ID_W-1:0] out_id_o,
  input logic [1:0]         job_status_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  // A stalled result keeps its item
  `JST_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(ok_o) && $stable(out_id_o) && $stable(job_status_o), "result changed while stalled")

  // A refused request never carries an id
  `JST_ASSERT_IMP(a_refused_no_id, clk_i, rst_ni, out_valid_o && !ok_o, out_id_o == '0, "refused request returned an id")

  // Configuration access never waits
  `JST_ASSERT_IMP(a_cfg_no_wait, clk_i, rst_ni, psel && penable, pready, "configuration access stalled")

  // Only the enable bit reads back nonzero
  `JST_ASSERT_IMP(a_prdata_pad, clk_i, rst_ni, psel, prdata[PDATA_W-1:1] == '0, "read data upper bits set")

endmodule

bind job_slot_tracker jst_checker u_jst_checker (.*);
